### hdl/mccp_pkg.sv
// shared types, constants and helpers of the mixed-criticality priority policy
package mccp_pkg;

	localparam int unsigned MAX_TASKS   = 16;
	localparam int unsigned IDX_W       = $clog2(MAX_TASKS);
	localparam int unsigned CNT_W       = IDX_W + 1;
	localparam logic [5:0]  LEVEL_TOP   = 6'd47;
	localparam logic [5:0]  SOFT_TOP    = 6'd31;
	localparam logic [5:0]  LEVEL_FLOOR = 6'd8;
	localparam logic [17:0] PERIOD_SAT  = 18'h3FFFF;
	localparam logic [6:0]  PCT_FULL    = 7'd100;

	// configuration register indexes
	localparam logic [2:0] CFG_TASK_COUNT  = 3'd0;
	localparam logic [2:0] CFG_HIGH_PCT    = 3'd1;
	localparam logic [2:0] CFG_LOW_PCT     = 3'd2;
	localparam logic [2:0] CFG_BUDGET      = 3'd3;
	localparam logic [2:0] CFG_MULTIPLIER  = 3'd4;
	localparam logic [2:0] CFG_PRIO_DROP   = 3'd5;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SELECT = 2'd1,
		ACT_REPORT = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ALG_RM     = 2'd0,
		ALG_DM     = 2'd1,
		ALG_CRIT   = 2'd2,
		ALG_UNUSED = 2'd3
	} alg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_SEL_RD,
		ST_SEL_RANK,
		ST_SEL_WR,
		ST_RP_RD,
		ST_RP_MUL,
		ST_RP_ADD,
		ST_J_MUL,
		ST_J_CHK,
		ST_J_DIV,
		ST_J_PICK,
		ST_DG_RD,
		ST_DG_WR,
		ST_EM_PRE,
		ST_EM_RD
	} state_t;

	// one task table entry as held in the memory
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] deadline;
		logic [23:0] work;
		logic        hard;
		logic [5:0]  base_level;
		logic [5:0]  act_prio;
		logic [17:0] act_period;
		logic        degraded;
		logic [31:0] prev_rel;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [4:0]  task_count;
		logic [6:0]  high_pct;
		logic [6:0]  low_pct;
		logic [31:0] budget;
		logic [2:0]  multiplier;
		logic [3:0]  prio_drop;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  task_index;
		logic [15:0] task_period;
		logic [15:0] task_deadline;
		logic [23:0] work_units;
		logic        hard_task;
		logic [1:0]  algorithm;
		logic [31:0] release_total;
		logic        window_end;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  out_task;
		logic [5:0]  priority_res;
		logic [17:0] current_period;
		logic        is_degraded;
		logic        degraded_mode;
		logic [6:0]  load_pct;
		logic [31:0] mode_change_count;
		logic        last;
	} out_item_t;

	// descending priority ladder, floored at the lowest level
	function automatic logic [5:0] ladder(input logic [5:0] top, input logic [CNT_W-1:0] rank);
		logic [6:0] r;
		begin
			r = 7'(rank);
			if (r >= 7'(top - LEVEL_FLOOR)) begin
				ladder = LEVEL_FLOOR;
			end else begin
				ladder = top - 6'(rank);
			end
		end
	endfunction

endpackage

### hdl/mccp_ram.sv
// task table memory: one write port, two registered read ports
module mccp_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, both registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### hdl/mccp_ctrl.sv
// sequencer: table updates, ranking, load judgment and result emission
module mccp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mccp_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mccp_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mccp_pkg::out_item_t  out_item,
	output logic                 ram_we,
	output logic [mccp_pkg::IDX_W-1:0] ram_waddr,
	output mccp_pkg::entry_t     ram_wdata,
	output logic [mccp_pkg::IDX_W-1:0] ram_raddr_a,
	output logic [mccp_pkg::IDX_W-1:0] ram_raddr_b,
	input  mccp_pkg::entry_t     ram_rdata_a,
	input  mccp_pkg::entry_t     ram_rdata_b
);

	mccp_pkg::state_t   state_q, state_d;
	mccp_pkg::in_item_t item_q;
	logic [mccp_pkg::CNT_W-1:0] i_q, j_q, j_s1, rank_q, n;
	logic        jv_s1;
	logic [1:0]  alg_q;
	logic        mode_q, dir_q, big_q, hi_q, lo_q;
	logic [31:0] tc_q;
	logic [63:0] ww_q;
	logic [55:0] prod_q;
	logic [38:0] w100_q;
	logic [31:0] rem_q;
	logic [2:0]  step_q;
	logic [6:0]  load_q;
	logic [mccp_pkg::MAX_TASKS-1:0] valid_q;
	logic        va_q, vb_q;
	mccp_pkg::entry_t ent_a, ent_b;
	logic        accept, i_live, i_final, slot_free, rank_hit, do_rank, emit;
	logic [15:0] key_a, key_b;
	logic [32:0] div_t;
	logic        div_bit;
	logic [31:0] delta;
	logic [2:0]  mult;
	logic [18:0] deg_per;
	logic [6:0]  drop_lim;
	logic [38:0] hi_prod, lo_prod;

	// live task count, saturated at the table size
	assign n = (cfg.task_count > mccp_pkg::CNT_W'(mccp_pkg::MAX_TASKS)) ?
		mccp_pkg::CNT_W'(mccp_pkg::MAX_TASKS) : cfg.task_count;

	assign in_stall  = (state_q != mccp_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign i_live    = (i_q < n);
	assign i_final   = (i_q + 1'b1 == n);
	assign slot_free = !out_valid || !out_stall;
	assign emit      = (state_q == mccp_pkg::ST_EM_RD) && slot_free;

	// never-written entries read as reset values
	assign ent_a = va_q ? ram_rdata_a : '0;
	assign ent_b = vb_q ? ram_rdata_b : '0;

	// ranking compare
	assign do_rank = (alg_q != mccp_pkg::ALG_UNUSED) && i_live;
	assign key_a = (alg_q == mccp_pkg::ALG_RM) ? ent_a.period : ent_a.deadline;
	assign key_b = (alg_q == mccp_pkg::ALG_RM) ? ent_b.period : ent_b.deadline;
	assign rank_hit = jv_s1 && (j_s1 != i_q) &&
		!((alg_q == mccp_pkg::ALG_CRIT) && (ent_a.hard != ent_b.hard)) &&
		((key_b < key_a) || ((key_b == key_a) && (j_s1 < i_q)));

	// restoring division step
	assign div_t   = {rem_q, w100_q[step_q]};
	assign div_bit = (div_t >= {1'b0, cfg.budget});

	// release delta and degraded values
	assign delta    = item_q.release_total - ent_a.prev_rel;
	assign mult     = (cfg.multiplier == 3'd0) ? 3'd1 : cfg.multiplier;
	assign deg_per  = 19'(ent_a.period) * 19'(mult);
	assign drop_lim = 7'(cfg.prio_drop) + 7'(mccp_pkg::LEVEL_FLOOR);
	assign hi_prod  = 39'(cfg.high_pct) * 39'(cfg.budget);
	assign lo_prod  = 39'(cfg.low_pct) * 39'(cfg.budget);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mccp_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_item.action)
						mccp_pkg::ACT_LOAD:   state_d = mccp_pkg::ST_LD_RD;
						mccp_pkg::ACT_SELECT: state_d = mccp_pkg::ST_SEL_RD;
						mccp_pkg::ACT_REPORT: begin
							if (mccp_pkg::CNT_W'(in_item.task_index) < n) begin
								state_d = mccp_pkg::ST_RP_RD;
							end else if (in_item.window_end) begin
								state_d = mccp_pkg::ST_J_MUL;
							end
						end
						default: state_d = mccp_pkg::ST_IDLE;
					endcase
				end
			end
			mccp_pkg::ST_LD_RD:  state_d = mccp_pkg::ST_LD_WR;
			mccp_pkg::ST_LD_WR:  state_d = mccp_pkg::ST_IDLE;
			mccp_pkg::ST_SEL_RD: state_d = do_rank ? mccp_pkg::ST_SEL_RANK : mccp_pkg::ST_SEL_WR;
			mccp_pkg::ST_SEL_RANK: begin
				if (j_q == n && !jv_s1) begin
					state_d = mccp_pkg::ST_SEL_WR;
				end
			end
			mccp_pkg::ST_SEL_WR: begin
				if (i_q == mccp_pkg::CNT_W'(mccp_pkg::MAX_TASKS - 1)) begin
					state_d = (n == '0) ? mccp_pkg::ST_IDLE : mccp_pkg::ST_EM_PRE;
				end else begin
					state_d = mccp_pkg::ST_SEL_RD;
				end
			end
			mccp_pkg::ST_RP_RD:  state_d = mccp_pkg::ST_RP_MUL;
			mccp_pkg::ST_RP_MUL: state_d = mccp_pkg::ST_RP_ADD;
			mccp_pkg::ST_RP_ADD: state_d = item_q.window_end ? mccp_pkg::ST_J_MUL : mccp_pkg::ST_IDLE;
			mccp_pkg::ST_J_MUL:  state_d = mccp_pkg::ST_J_CHK;
			mccp_pkg::ST_J_CHK:  state_d = big_q ? mccp_pkg::ST_J_PICK : mccp_pkg::ST_J_DIV;
			mccp_pkg::ST_J_DIV:  state_d = (step_q == 3'd0) ? mccp_pkg::ST_J_PICK : mccp_pkg::ST_J_DIV;
			mccp_pkg::ST_J_PICK: begin
				if (n == '0) begin
					state_d = mccp_pkg::ST_IDLE;
				end else if (alg_q == mccp_pkg::ALG_CRIT &&
						((hi_q && !mode_q) || (lo_q && mode_q))) begin
					state_d = mccp_pkg::ST_DG_RD;
				end else begin
					state_d = mccp_pkg::ST_EM_PRE;
				end
			end
			mccp_pkg::ST_DG_RD:  state_d = mccp_pkg::ST_DG_WR;
			mccp_pkg::ST_DG_WR:  state_d = i_final ? mccp_pkg::ST_EM_PRE : mccp_pkg::ST_DG_RD;
			mccp_pkg::ST_EM_PRE: state_d = mccp_pkg::ST_EM_RD;
			mccp_pkg::ST_EM_RD: begin
				if (slot_free && i_final) begin
					state_d = mccp_pkg::ST_IDLE;
				end
			end
			default: state_d = mccp_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = i_q[mccp_pkg::IDX_W-1:0];
		ram_wdata   = ent_a;
		ram_raddr_a = i_q[mccp_pkg::IDX_W-1:0];
		ram_raddr_b = j_q[mccp_pkg::IDX_W-1:0];
		case (state_q)
			mccp_pkg::ST_LD_RD, mccp_pkg::ST_RP_RD, mccp_pkg::ST_RP_MUL: begin
				ram_raddr_a = item_q.task_index;
			end
			mccp_pkg::ST_LD_WR: begin
				ram_raddr_a        = item_q.task_index;
				ram_waddr          = item_q.task_index;
				ram_we             = 1'b1;
				ram_wdata.period   = item_q.task_period;
				ram_wdata.deadline = item_q.task_deadline;
				ram_wdata.work     = item_q.work_units;
				ram_wdata.hard     = item_q.hard_task;
			end
			mccp_pkg::ST_SEL_WR: begin
				ram_we               = 1'b1;
				ram_wdata.degraded   = 1'b0;
				ram_wdata.act_period = 18'(ent_a.period);
				if (i_live) begin
					if (alg_q != mccp_pkg::ALG_UNUSED) begin
						ram_wdata.base_level = (alg_q == mccp_pkg::ALG_CRIT && !ent_a.hard) ?
							mccp_pkg::ladder(mccp_pkg::SOFT_TOP, rank_q) :
							mccp_pkg::ladder(mccp_pkg::LEVEL_TOP, rank_q);
					end
					ram_wdata.act_prio = ram_wdata.base_level;
				end
			end
			mccp_pkg::ST_DG_WR: begin
				ram_we = 1'b1;
				if (!ent_a.hard && dir_q && !ent_a.degraded) begin
					ram_wdata.degraded   = 1'b1;
					ram_wdata.act_period = (deg_per > 19'(mccp_pkg::PERIOD_SAT)) ?
						mccp_pkg::PERIOD_SAT : deg_per[17:0];
					ram_wdata.act_prio   = (7'(ent_a.act_prio) >= drop_lim) ?
						ent_a.act_prio - 6'(cfg.prio_drop) : mccp_pkg::LEVEL_FLOOR;
				end else if (!ent_a.hard && !dir_q && ent_a.degraded) begin
					ram_wdata.degraded   = 1'b0;
					ram_wdata.act_period = 18'(ent_a.period);
					ram_wdata.act_prio   = ent_a.base_level;
				end
			end
			mccp_pkg::ST_RP_ADD: begin
				ram_raddr_a = item_q.task_index;
			end
			// read one entry ahead so each cycle can emit an item while the output is not stalled
			mccp_pkg::ST_EM_RD: begin
				ram_raddr_a = slot_free ? mccp_pkg::IDX_W'(i_q + 1'b1) :
					i_q[mccp_pkg::IDX_W-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == mccp_pkg::ST_RP_MUL) begin
			ram_we            = 1'b1;
			ram_waddr         = item_q.task_index;
			ram_wdata.prev_rel = item_q.release_total;
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mccp_pkg::ST_IDLE;
			valid_q   <= '0;
			alg_q     <= mccp_pkg::ALG_RM;
			mode_q    <= 1'b0;
			tc_q      <= '0;
			ww_q      <= '0;
			out_valid <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			jv_s1     <= 1'b0;
			va_q      <= 1'b0;
			vb_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			va_q    <= valid_q[ram_raddr_a];
			vb_q    <= valid_q[ram_raddr_b];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				mccp_pkg::ST_IDLE: begin
					if (accept) begin
						item_q <= in_item;
						i_q    <= '0;
						if (in_item.action == mccp_pkg::ACT_SELECT) begin
							mode_q <= 1'b0;
							alg_q  <= in_item.algorithm;
							load_q <= '0;
						end
					end
				end
				mccp_pkg::ST_SEL_RD: begin
					j_q    <= '0;
					jv_s1  <= 1'b0;
					rank_q <= '0;
				end
				mccp_pkg::ST_SEL_RANK: begin
					if (j_q < n) begin
						j_q <= j_q + 1'b1;
					end
					jv_s1 <= (j_q < n);
					j_s1  <= j_q;
					if (rank_hit) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				mccp_pkg::ST_SEL_WR: begin
					i_q <= (i_q == mccp_pkg::CNT_W'(mccp_pkg::MAX_TASKS - 1)) ? '0 : i_q + 1'b1;
				end
				mccp_pkg::ST_RP_MUL: begin
					prod_q <= 56'(delta) * 56'(ent_a.work);
				end
				mccp_pkg::ST_RP_ADD: begin
					ww_q <= ww_q + 64'(prod_q);
				end
				mccp_pkg::ST_J_MUL: begin
					big_q  <= (ww_q >= 64'(cfg.budget));
					w100_q <= 39'(ww_q[31:0]) * 39'(mccp_pkg::PCT_FULL);
				end
				mccp_pkg::ST_J_CHK: begin
					if (big_q) begin
						load_q <= mccp_pkg::PCT_FULL;
						hi_q   <= (mccp_pkg::PCT_FULL >= cfg.high_pct);
						lo_q   <= (mccp_pkg::PCT_FULL <= cfg.low_pct);
					end else begin
						load_q <= '0;
						hi_q   <= (w100_q >= hi_prod);
						lo_q   <= (w100_q <= lo_prod);
						rem_q  <= w100_q[38:7];
						step_q <= 3'd6;
					end
				end
				mccp_pkg::ST_J_DIV: begin
					load_q <= {load_q[5:0], div_bit};
					rem_q  <= div_bit ? 32'(div_t - {1'b0, cfg.budget}) : div_t[31:0];
					step_q <= step_q - 1'b1;
				end
				mccp_pkg::ST_J_PICK: begin
					ww_q <= '0;
					i_q  <= '0;
					if (alg_q == mccp_pkg::ALG_CRIT && hi_q && !mode_q) begin
						mode_q <= 1'b1;
						dir_q  <= 1'b1;
						tc_q   <= tc_q + 1'b1;
					end else if (alg_q == mccp_pkg::ALG_CRIT && lo_q && mode_q) begin
						mode_q <= 1'b0;
						dir_q  <= 1'b0;
						tc_q   <= tc_q + 1'b1;
					end
				end
				mccp_pkg::ST_DG_WR: begin
					i_q <= i_final ? '0 : i_q + 1'b1;
				end
				mccp_pkg::ST_EM_RD: begin
					if (slot_free) begin
						out_item.out_task          <= i_q[mccp_pkg::IDX_W-1:0];
						out_item.priority_res      <= ent_a.act_prio;
						out_item.current_period    <= ent_a.act_period;
						out_item.is_degraded       <= ent_a.degraded;
						out_item.degraded_mode     <= mode_q;
						out_item.load_pct          <= load_q;
						out_item.mode_change_count <= tc_q;
						out_item.last              <= i_final;
						i_q                        <= i_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/mixed_criticality_priority_policy.sv
// top level: configuration registers, task table memory and sequencer
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | action .. window_end
//  output   | out_valid/ out_stall | out_task .. last
//  config   | cfg_we               | cfg_index, cfg_data
//
// load: read, then write of the entry; report: read, multiply and add states, plus at
// a window end a judgment (multiply, check, division steps skipped when the load
// is full, pick), a degrade pass over the live tasks and one emission per item.
// select: a ranking scan per live entry (one compare per cycle through the second
// read port), a write of every table entry, then emission of each live task.
// reset clears the state register, valid flags, mode and transition count; table entries read as zero until written.
// one item at a time; output stall holds the sequencer only during emission.
module mixed_criticality_priority_policy (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  task_index,
	input  logic [15:0] task_period,
	input  logic [15:0] task_deadline,
	input  logic [23:0] work_units,
	input  logic        hard_task,
	input  logic [1:0]  algorithm,
	input  logic [31:0] release_total,
	input  logic        window_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  out_task,
	output logic [5:0]  priority_res,
	output logic [17:0] current_period,
	output logic        is_degraded,
	output logic        degraded_mode,
	output logic [6:0]  load_pct,
	output logic [31:0] mode_change_count,
	output logic        last
);

	mccp_pkg::cfg_t      cfg_q;
	mccp_pkg::in_item_t  in_item;
	mccp_pkg::out_item_t out_item;
	logic                ram_we;
	logic [mccp_pkg::IDX_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
	mccp_pkg::entry_t    ram_wdata, ram_rdata_a, ram_rdata_b;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.task_count <= 5'd10;
			cfg_q.high_pct   <= 7'd75;
			cfg_q.low_pct    <= 7'd55;
			cfg_q.budget     <= 32'd2100000;
			cfg_q.multiplier <= 3'd2;
			cfg_q.prio_drop  <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				mccp_pkg::CFG_TASK_COUNT: cfg_q.task_count <= cfg_data[4:0];
				mccp_pkg::CFG_HIGH_PCT:   cfg_q.high_pct   <= cfg_data[6:0];
				mccp_pkg::CFG_LOW_PCT:    cfg_q.low_pct    <= cfg_data[6:0];
				mccp_pkg::CFG_BUDGET:     cfg_q.budget     <= cfg_data;
				mccp_pkg::CFG_MULTIPLIER: cfg_q.multiplier <= cfg_data[2:0];
				mccp_pkg::CFG_PRIO_DROP:  cfg_q.prio_drop  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// input item bundle
	assign in_item.action        = action;
	assign in_item.task_index    = task_index;
	assign in_item.task_period   = task_period;
	assign in_item.task_deadline = task_deadline;
	assign in_item.work_units    = work_units;
	assign in_item.hard_task     = hard_task;
	assign in_item.algorithm     = algorithm;
	assign in_item.release_total = release_total;
	assign in_item.window_end    = window_end;

	// output item fields
	assign out_task          = out_item.out_task;
	assign priority_res      = out_item.priority_res;
	assign current_period    = out_item.current_period;
	assign is_degraded       = out_item.is_degraded;
	assign degraded_mode     = out_item.degraded_mode;
	assign load_pct          = out_item.load_pct;
	assign mode_change_count = out_item.mode_change_count;
	assign last              = out_item.last;

	// task table
	mccp_ram #(
		.DATA_W(mccp_pkg::ENTRY_W),
		.ADDR_W(mccp_pkg::IDX_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// sequencer
	mccp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

endmodule
